>>> hw/rtl/bmp_pkg.sv
package bmp_pkg;

	// record kinds
	localparam logic [4:0] KIND_HEADER    = 5'd0;
	localparam logic [4:0] KIND_VERSION   = 5'd1;
	localparam logic [4:0] KIND_ASN       = 5'd2;
	localparam logic [4:0] KIND_HOLD      = 5'd3;
	localparam logic [4:0] KIND_IDENT     = 5'd4;
	localparam logic [4:0] KIND_AS4_CAP   = 5'd5;
	localparam logic [4:0] KIND_WITHDRAWN = 5'd6;
	localparam logic [4:0] KIND_ATTR_HDR  = 5'd7;
	localparam logic [4:0] KIND_ORIGIN    = 5'd8;
	localparam logic [4:0] KIND_AS_PATH   = 5'd9;
	localparam logic [4:0] KIND_ATOMIC    = 5'd13;
	localparam logic [4:0] KIND_AGGR      = 5'd14;
	localparam logic [4:0] KIND_AS4_PATH  = 5'd15;
	localparam logic [4:0] KIND_AGGR4     = 5'd16;
	localparam logic [4:0] KIND_NLRI      = 5'd17;
	localparam logic [4:0] KIND_ERROR     = 5'd18;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_MARKER   = 3'd1;
	localparam logic [2:0] ERR_TOO_LONG = 3'd2;
	localparam logic [2:0] ERR_PREFIX   = 3'd3;
	localparam logic [2:0] ERR_ATOMIC   = 3'd4;
	localparam logic [2:0] ERR_NLRI_NEG = 3'd5;

	// attribute type codes
	localparam logic [7:0] AT_ORIGIN    = 8'd1;
	localparam logic [7:0] AT_AS_PATH   = 8'd2;
	localparam logic [7:0] AT_NEXT_HOP  = 8'd3;
	localparam logic [7:0] AT_MED       = 8'd4;
	localparam logic [7:0] AT_LOCAL_PREF = 8'd5;
	localparam logic [7:0] AT_ATOMIC    = 8'd6;
	localparam logic [7:0] AT_AGGR      = 8'd7;
	localparam logic [7:0] AT_AS4_PATH  = 8'd17;
	localparam logic [7:0] AT_AGGR4     = 8'd18;

	localparam logic [7:0] CAP_AS4      = 8'd65;
	localparam logic [7:0] MSG_OPEN     = 8'd1;
	localparam logic [7:0] MSG_UPDATE   = 8'd2;
	localparam logic [7:0] PARAM_CAP    = 8'd2;
	localparam logic [15:0] RESET_MAX_LEN = 16'd4096;
	localparam logic [17:0] UPDATE_FIXED = 18'd23;

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] pv;
		logic [31:0] sv;
		logic [5:0]  plen;
		logic [3:0]  flags;
		logic [7:0]  atype;
		logic [15:0] alen;
		logic [2:0]  err;
		logic        done;
		logic        last;
	} rec_t;

	// one queue entry: the records caused by one byte
	typedef struct packed {
		logic two;
		rec_t r0;
		rec_t r1;
	} entry_t;

	typedef struct packed {
		logic   nonempty;
		entry_t head;
	} q_status_t;

	function automatic rec_t mk_rec(input logic [4:0] kind, input logic [31:0] pv,
			input logic [31:0] sv, input logic [5:0] plen, input logic attr,
			input logic [3:0] flags, input logic [7:0] atype, input logic [15:0] alen,
			input logic [2:0] err);
		rec_t r;
		r = '0;
		r.kind = kind;
		r.pv = pv;
		r.sv = sv;
		r.plen = plen;
		r.err = err;
		if (attr) begin
			r.flags = flags;
			r.atype = atype;
			r.alen = alen;
		end
		return r;
	endfunction

	function automatic logic [15:0] dec16(input logic [15:0] v);
		return (v != 16'd0) ? v - 16'd1 : 16'd0;
	endfunction

	function automatic logic [7:0] dec8(input logic [7:0] v);
		return (v != 8'd0) ? v - 8'd1 : 8'd0;
	endfunction

endpackage

>>> hw/rtl/bgp_message_parser_unit.sv
// a record passes from the byte that causes it through the entry queue and then the output register
// throughput: one byte per cycle while bytes cause at most one record each and the queue is not full
// a byte with two records holds the single output register for both of its records in turn;
// the entry queue of QueueDepth entries absorbs that and output stalls until it fills
// reset: parser idle until a message start, queue empty, length limit 4096
module bgp_message_parser_unit #(
	parameter int QueueDepth = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  message_byte,
	input  logic        message_start,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  record_kind,
	output logic [31:0] primary_value,
	output logic [31:0] secondary_value,
	output logic [5:0]  prefix_length,
	output logic [3:0]  attr_flags,
	output logic [7:0]  attr_type,
	output logic [15:0] attr_length,
	output logic [2:0]  error_code,
	output logic        message_done,
	output logic        last_in_run
);

	logic [15:0]            max_len_q;
	logic                   full, push, pop, accept;
	bmp_pkg::entry_t        entry;
	bmp_pkg::q_status_t     status;
	bmp_pkg::rec_t          rec;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign accept = in_valid && !full;

	// length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_len_q <= bmp_pkg::RESET_MAX_LEN;
		else if (cfg_valid && cfg_ready) max_len_q <= cfg_data;
	end

	bmp_front u_front (
		.clk, .arst_n, .accept, .message_byte, .message_start,
		.max_len(max_len_q), .push, .entry
	);

	bmp_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .push, .wdata(entry), .pop, .full, .status
	);

	bmp_back u_back (
		.clk, .arst_n, .status, .pop, .out_stall, .out_valid, .rec
	);

	assign record_kind = rec.kind;
	assign primary_value = rec.pv;
	assign secondary_value = rec.sv;
	assign prefix_length = rec.plen;
	assign attr_flags = rec.flags;
	assign attr_type = rec.atype;
	assign attr_length = rec.alen;
	assign error_code = rec.err;
	assign message_done = rec.done;
	assign last_in_run = rec.last;

endmodule

>>> hw/rtl/bmp_front.sv
module bmp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          message_byte,
	input  logic                message_start,
	input  logic [15:0]         max_len,
	output logic                push,
	output bmp_pkg::entry_t     entry
);

	typedef enum logic [4:0] {
		PH_IDLE, PH_HEAD, PH_SKIP, PH_OPEN, PH_O_PTYPE, PH_O_PLEN, PH_O_PBODY,
		PH_O_CCODE, PH_O_CLEN, PH_O_CVAL, PH_U_WLEN, PH_U_WPLEN, PH_U_WPFX,
		PH_U_ALEN, PH_U_AFLAGS, PH_U_ATYPE, PH_U_ALENB, PH_U_AVAL, PH_U_NPLEN,
		PH_U_NPFX
	} phase_t;

	phase_t      ph_q, n_ph;
	logic [15:0] pos_q, n_pos, mlen_q, n_mlen, sr_q, n_sr, ir_q, n_ir;
	logic [15:0] wt_q, n_wt, at_q, n_at, cal_q, n_cal;
	logic [31:0] fa_q, n_fa, agg_q, n_agg;
	logic [3:0]  caf_q, n_caf;
	logic [7:0]  cat_q, n_cat, pel_q, n_pel, seg_q, n_seg;
	logic        pew_q, n_pew;
	logic [5:0]  cpb_q, n_cpb;

	logic [1:0]  nrec;
	bmp_pkg::rec_t r0, r1, e;
	logic        failed, ends, route_fin, route_nlri, attr_go;
	logic [7:0]  b;
	logic [15:0] idx, off, kk, msk;
	logic [6:0]  nbytes;
	logic [17:0] need;

	// byte decode, step by step as the message grammar runs
	always_comb begin
		n_ph = ph_q; n_pos = pos_q; n_mlen = mlen_q; n_sr = sr_q; n_ir = ir_q;
		n_wt = wt_q; n_at = at_q; n_cal = cal_q; n_fa = fa_q; n_agg = agg_q;
		n_caf = caf_q; n_cat = cat_q; n_pel = pel_q; n_seg = seg_q; n_pew = pew_q;
		n_cpb = cpb_q;
		nrec = 2'd0; r0 = '0; r1 = '0; e = '0;
		failed = 1'b0; ends = 1'b0; route_fin = 1'b0; route_nlri = 1'b0;
		attr_go = 1'b0;
		b = message_byte;
		idx = '0; off = '0; kk = '0; msk = '0; nbytes = '0; need = '0;
		if (accept && message_start) begin
			n_pos = '0; n_mlen = '0; n_sr = '0; n_ir = '0; n_wt = '0; n_at = '0;
			n_cal = '0; n_fa = '0; n_agg = '0; n_caf = '0; n_cat = '0; n_pel = '0;
			n_seg = '0; n_pew = 1'b0; n_cpb = '0;
			n_ph = PH_HEAD;
		end
		if (accept && n_ph != PH_IDLE) begin
			ends = (n_pos >= 16'd18) && ({1'b0, n_pos} + 17'd1 >= {1'b0, n_mlen});
			unique case (n_ph)
				PH_HEAD: begin
					if (n_pos < 16'd16) begin
						if (b != 8'hFF) begin
							failed = 1'b1;
							e = bmp_pkg::mk_rec(bmp_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
								'0, '0, '0, bmp_pkg::ERR_MARKER);
							r0 = e; nrec = 2'd1;
						end
					end else if (n_pos == 16'd16) begin
						n_mlen = {b, 8'd0};
					end else if (n_pos == 16'd17) begin
						n_mlen = {n_mlen[15:8], b};
						if (n_mlen > max_len) begin
							failed = 1'b1;
							e = bmp_pkg::mk_rec(bmp_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
								'0, '0, '0, bmp_pkg::ERR_TOO_LONG);
							r0 = e; nrec = 2'd1;
						end
					end else begin
						e = bmp_pkg::mk_rec(bmp_pkg::KIND_HEADER, {24'd0, b},
							{16'd0, n_mlen}, '0, 1'b0, '0, '0, '0, bmp_pkg::ERR_NONE);
						r0 = e; nrec = 2'd1;
						n_ph = (b == bmp_pkg::MSG_OPEN) ? PH_OPEN :
							(b == bmp_pkg::MSG_UPDATE) ? PH_U_WLEN : PH_SKIP;
					end
				end
				PH_OPEN: begin
					off = n_pos - 16'd19;
					if (off == 16'd0) begin
						e = bmp_pkg::mk_rec(bmp_pkg::KIND_VERSION, {24'd0, b}, '0, '0,
							1'b0, '0, '0, '0, bmp_pkg::ERR_NONE);
						r0 = e; nrec = 2'd1;
					end else begin
						n_fa = (off == 16'd1 || off == 16'd3 || off == 16'd5) ?
							{24'd0, b} : {n_fa[23:0], b};
						if (off == 16'd2 || off == 16'd4 || off == 16'd8) begin
							e = bmp_pkg::mk_rec((off == 16'd2) ? bmp_pkg::KIND_ASN :
								(off == 16'd4) ? bmp_pkg::KIND_HOLD : bmp_pkg::KIND_IDENT,
								n_fa, '0, '0, 1'b0, '0, '0, '0, bmp_pkg::ERR_NONE);
							r0 = e; nrec = 2'd1;
						end else if (off == 16'd9) begin
							n_sr = {8'd0, b};
							n_ph = (b != 8'd0) ? PH_O_PTYPE : PH_SKIP;
						end
					end
				end
				PH_O_PTYPE: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_cat = b;
					n_ph = PH_O_PLEN;
				end
				PH_O_PLEN: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_ir = {8'd0, b};
					if (b == 8'd0) n_ph = (n_sr != 16'd0) ? PH_O_PTYPE : PH_SKIP;
					else n_ph = (n_cat == bmp_pkg::PARAM_CAP) ? PH_O_CCODE : PH_O_PBODY;
				end
				PH_O_PBODY: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_ir = bmp_pkg::dec16(n_ir);
					if (n_ir == 16'd0) n_ph = (n_sr != 16'd0) ? PH_O_PTYPE : PH_SKIP;
				end
				PH_O_CCODE: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_ir = bmp_pkg::dec16(n_ir);
					n_seg = b;
					n_ph = PH_O_CLEN;
				end
				PH_O_CLEN: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_ir = bmp_pkg::dec16(n_ir);
					n_pel = b;
					n_cal = {8'd0, b};
					n_fa = '0;
					if (b == 8'd0) begin
						if (n_ir == 16'd0) n_ph = (n_sr != 16'd0) ? PH_O_PTYPE : PH_SKIP;
						else n_ph = PH_O_CCODE;
					end else begin
						n_ph = PH_O_CVAL;
					end
				end
				PH_O_CVAL: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_ir = bmp_pkg::dec16(n_ir);
					n_fa = {n_fa[23:0], b};
					if (n_seg == bmp_pkg::CAP_AS4 && n_cal - {8'd0, n_pel} == 16'd3) begin
						e = bmp_pkg::mk_rec(bmp_pkg::KIND_AS4_CAP, n_fa, '0, '0, 1'b0,
							'0, '0, '0, bmp_pkg::ERR_NONE);
						r0 = e; nrec = 2'd1;
					end
					n_pel = bmp_pkg::dec8(n_pel);
					if (n_pel == 8'd0) begin
						if (n_ir == 16'd0) n_ph = (n_sr != 16'd0) ? PH_O_PTYPE : PH_SKIP;
						else n_ph = PH_O_CCODE;
					end
				end
				PH_U_WLEN: begin
					if (n_pos == 16'd19) begin
						n_wt = {b, 8'd0};
					end else begin
						n_wt = {n_wt[15:8], b};
						n_sr = n_wt;
						if (n_wt != 16'd0) begin
							n_ph = PH_U_WPLEN;
						end else begin
							n_ph = PH_U_ALEN;
							n_ir = 16'd2;
						end
					end
				end
				PH_U_WPLEN, PH_U_NPLEN: begin
					route_nlri = (n_ph == PH_U_NPLEN);
					if (!route_nlri) n_sr = bmp_pkg::dec16(n_sr);
					if (b > 8'd32) begin
						failed = 1'b1;
						e = bmp_pkg::mk_rec(bmp_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
							'0, '0, '0, bmp_pkg::ERR_PREFIX);
						r0 = e; nrec = 2'd1;
					end else begin
						n_cpb = b[5:0];
						n_fa = '0;
						n_ir = ({8'd0, b} + 16'd7) >> 3;
						if (n_ir == 16'd0) route_fin = 1'b1;
						else n_ph = route_nlri ? PH_U_NPFX : PH_U_WPFX;
					end
				end
				PH_U_WPFX, PH_U_NPFX: begin
					route_nlri = (n_ph == PH_U_NPFX);
					if (!route_nlri) n_sr = bmp_pkg::dec16(n_sr);
					nbytes = ({1'b0, n_cpb} + 7'd7) >> 3;
					kk = {9'd0, nbytes} - n_ir;
					n_fa = n_fa | ({24'd0, b} << {2'd3 - kk[1:0], 3'd0});
					n_ir = n_ir - 16'd1;
					if (n_ir == 16'd0) route_fin = 1'b1;
				end
				PH_U_ALEN: begin
					if (n_ir == 16'd2) begin
						n_at = {b, 8'd0};
						n_ir = 16'd1;
					end else begin
						n_at = {n_at[15:8], b};
						need = bmp_pkg::UPDATE_FIXED + {2'd0, n_wt} + {2'd0, n_at};
						if (need > {2'd0, n_mlen}) begin
							failed = 1'b1;
							e = bmp_pkg::mk_rec(bmp_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
								'0, '0, '0, bmp_pkg::ERR_NLRI_NEG);
							r0 = e; nrec = 2'd1;
						end else begin
							n_sr = n_at;
							n_ph = (n_at != 16'd0) ? PH_U_AFLAGS : PH_U_NPLEN;
						end
					end
				end
				PH_U_AFLAGS: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_caf = b[7:4];
					n_ph = PH_U_ATYPE;
				end
				PH_U_ATYPE: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_cat = b;
					n_ir = n_caf[0] ? 16'd2 : 16'd1;
					n_cal = '0;
					n_ph = PH_U_ALENB;
				end
				PH_U_ALENB: begin
					n_sr = bmp_pkg::dec16(n_sr);
					n_cal = {n_cal[7:0], b};
					n_ir = bmp_pkg::dec16(n_ir);
					if (n_ir == 16'd0) attr_go = 1'b1;
				end
				PH_U_AVAL: begin
					idx = n_cal - n_ir;
					n_sr = bmp_pkg::dec16(n_sr);
					n_ir = bmp_pkg::dec16(n_ir);
					if (n_cat == bmp_pkg::AT_AS_PATH || n_cat == bmp_pkg::AT_AS4_PATH) begin
						if (idx == 16'd0) begin
							n_seg = b;
						end else if (idx == 16'd1) begin
							n_pel = b;
							n_pew = (n_cat == bmp_pkg::AT_AS4_PATH) ||
								({6'd0, b, 2'd0} + 16'd2 == n_cal);
							n_fa = '0;
						end else if (n_pel != 8'd0) begin
							n_fa = {n_fa[23:0], b};
							msk = n_pew ? 16'd3 : 16'd1;
							if (((idx - 16'd2) & msk) == msk) begin
								e = bmp_pkg::mk_rec((n_cat == bmp_pkg::AT_AS_PATH) ?
									bmp_pkg::KIND_AS_PATH : bmp_pkg::KIND_AS4_PATH,
									n_fa, {24'd0, n_seg}, '0, 1'b1, n_caf, n_cat, n_cal,
									bmp_pkg::ERR_NONE);
								r0 = e; nrec = 2'd1;
								n_fa = '0;
								n_pel = n_pel - 8'd1;
							end
						end
					end else begin
						n_fa = {n_fa[23:0], b};
						if (n_cat == bmp_pkg::AT_ORIGIN && idx == 16'd0) begin
							e = bmp_pkg::mk_rec(bmp_pkg::KIND_ORIGIN, {24'd0, b}, '0, '0,
								1'b1, n_caf, n_cat, n_cal, bmp_pkg::ERR_NONE);
							r0 = e; nrec = 2'd1;
						end else if ((n_cat == bmp_pkg::AT_NEXT_HOP ||
								n_cat == bmp_pkg::AT_MED || n_cat == bmp_pkg::AT_LOCAL_PREF)
								&& idx == 16'd3) begin
							e = bmp_pkg::mk_rec(n_cat[4:0] + 5'd7, n_fa, '0, '0, 1'b1,
								n_caf, n_cat, n_cal, bmp_pkg::ERR_NONE);
							r0 = e; nrec = 2'd1;
						end else if (n_cat == bmp_pkg::AT_AGGR && idx == 16'd1) begin
							n_agg = {16'd0, n_fa[15:0]};
							n_fa = '0;
						end else if (n_cat == bmp_pkg::AT_AGGR && idx == 16'd5) begin
							e = bmp_pkg::mk_rec(bmp_pkg::KIND_AGGR, n_agg, n_fa, '0, 1'b1,
								n_caf, n_cat, n_cal, bmp_pkg::ERR_NONE);
							r0 = e; nrec = 2'd1;
						end else if (n_cat == bmp_pkg::AT_AGGR4 && idx == 16'd3) begin
							n_agg = n_fa;
							n_fa = '0;
						end else if (n_cat == bmp_pkg::AT_AGGR4 && idx == 16'd7) begin
							e = bmp_pkg::mk_rec(bmp_pkg::KIND_AGGR4, n_agg, n_fa, '0, 1'b1,
								n_caf, n_cat, n_cal, bmp_pkg::ERR_NONE);
							r0 = e; nrec = 2'd1;
						end
					end
					if (n_ir == 16'd0) n_ph = (n_sr != 16'd0) ? PH_U_AFLAGS : PH_U_NPLEN;
				end
				default: begin
				end
			endcase

			// end of a route
			if (route_fin) begin
				e = bmp_pkg::mk_rec(route_nlri ? bmp_pkg::KIND_NLRI :
					bmp_pkg::KIND_WITHDRAWN, n_fa, '0, n_cpb, 1'b0, '0, '0, '0,
					bmp_pkg::ERR_NONE);
				r0 = e; nrec = 2'd1;
				if (route_nlri) begin
					n_ph = PH_U_NPLEN;
				end else if (n_sr == 16'd0) begin
					n_ph = PH_U_ALEN;
					n_ir = 16'd2;
				end else begin
					n_ph = PH_U_WPLEN;
				end
			end

			// attribute header and zero-length handling
			if (attr_go) begin
				r0 = bmp_pkg::mk_rec(bmp_pkg::KIND_ATTR_HDR, '0, '0, '0, 1'b1, n_caf,
					n_cat, n_cal, bmp_pkg::ERR_NONE);
				nrec = 2'd1;
				if (n_cat == bmp_pkg::AT_ATOMIC) begin
					if (n_cal != 16'd0) begin
						failed = 1'b1;
						r1 = bmp_pkg::mk_rec(bmp_pkg::KIND_ERROR, '0, '0, '0, 1'b0,
							'0, '0, '0, bmp_pkg::ERR_ATOMIC);
					end else begin
						r1 = bmp_pkg::mk_rec(bmp_pkg::KIND_ATOMIC, 32'd1, '0, '0, 1'b1,
							n_caf, n_cat, n_cal, bmp_pkg::ERR_NONE);
						n_ph = (n_sr != 16'd0) ? PH_U_AFLAGS : PH_U_NPLEN;
					end
					nrec = 2'd2;
				end else if (n_cal == 16'd0) begin
					n_ph = (n_sr != 16'd0) ? PH_U_AFLAGS : PH_U_NPLEN;
				end else begin
					n_ir = n_cal;
					n_fa = '0;
					n_ph = PH_U_AVAL;
				end
			end

			if (failed || ends) n_ph = PH_IDLE;
			else n_pos = n_pos + 16'd1;
		end
		r0.done = ends;
		r1.done = ends;
		r0.last = (nrec == 2'd1);
		r1.last = 1'b1;
	end

	assign push = (nrec != 2'd0);
	assign entry = '{two: (nrec == 2'd2), r0: r0, r1: r1};

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			pos_q <= '0; mlen_q <= '0; sr_q <= '0; ir_q <= '0; wt_q <= '0;
			at_q <= '0; cal_q <= '0; fa_q <= '0; agg_q <= '0; caf_q <= '0;
			cat_q <= '0; pel_q <= '0; seg_q <= '0; pew_q <= 1'b0; cpb_q <= '0;
		end else begin
			ph_q <= n_ph;
			pos_q <= n_pos; mlen_q <= n_mlen; sr_q <= n_sr; ir_q <= n_ir; wt_q <= n_wt;
			at_q <= n_at; cal_q <= n_cal; fa_q <= n_fa; agg_q <= n_agg; caf_q <= n_caf;
			cat_q <= n_cat; pel_q <= n_pel; seg_q <= n_seg; pew_q <= n_pew; cpb_q <= n_cpb;
		end
	end

	// a byte taken while idle without a start causes nothing
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !message_start && ph_q == PH_IDLE) |-> !push)
		else $error("record from idle parser");

endmodule

>>> hw/rtl/bmp_queue.sv
module bmp_queue #(
	parameter int Depth = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bmp_pkg::entry_t       wdata,
	input  logic                  pop,
	output logic                  full,
	output bmp_pkg::q_status_t    status
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
	localparam logic [CW-1:0] Full = CW'(Depth);

	bmp_pkg::entry_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == Full);
	assign status = '{nonempty: (count_q != '0), head: mem_q[rd_q]};

	// entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop) else $error("queue underflow");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("fill count mismatch");

endmodule

>>> hw/rtl/bmp_back.sv
module bmp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bmp_pkg::q_status_t    status,
	output logic                  pop,
	input  logic                  out_stall,
	output logic                  out_valid,
	output bmp_pkg::rec_t         rec
);

	logic          sub_q, load;
	logic          out_valid_q;
	bmp_pkg::rec_t rec_q;

	// output register may take a new record when empty or being drained
	assign load = !out_valid_q || !out_stall;
	assign pop = load && status.nonempty && (sub_q || !status.head.two);
	assign out_valid = out_valid_q;
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (load && status.nonempty) rec_q <= sub_q ? status.head.r1 : status.head.r0;
	end

	// walk the records of the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= status.nonempty;
			if (status.nonempty) sub_q <= !sub_q && status.head.two;
		end
	end

	a_sub_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q |-> status.nonempty) else $error("second record without entry");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
module testbench;

	// kinds not named in the package
	localparam logic [4:0] KIND_NEXT_HOP  = 5'd10;
	localparam logic [4:0] KIND_MED       = 5'd11;
	localparam logic [4:0] KIND_LOCAL_PREF = 5'd12;
	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD = 300;

	typedef enum logic [4:0] {
		PS_IDLE, PS_HEAD, PS_SKIP, PS_OPEN, PS_PTYPE, PS_PLEN, PS_PBODY, PS_CCODE,
		PS_CLEN, PS_CVAL, PS_WLEN, PS_WPLEN, PS_WPFX, PS_ALEN, PS_AFLAGS, PS_ATYPE,
		PS_ALENB, PS_AVAL, PS_NPLEN, PS_NPFX
	} parse_state_t;

	typedef struct packed {
		logic [7:0] b;
		logic       s;
	} stream_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  message_byte;
	logic        message_start;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  record_kind;
	logic [31:0] primary_value;
	logic [31:0] secondary_value;
	logic [5:0]  prefix_length;
	logic [3:0]  attr_flags;
	logic [7:0]  attr_type;
	logic [15:0] attr_length;
	logic [2:0]  error_code;
	logic        message_done;
	logic        last_in_run;

	bgp_message_parser_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.message_byte(message_byte), .message_start(message_start),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.record_kind(record_kind), .primary_value(primary_value),
		.secondary_value(secondary_value), .prefix_length(prefix_length),
		.attr_flags(attr_flags), .attr_type(attr_type), .attr_length(attr_length),
		.error_code(error_code), .message_done(message_done), .last_in_run(last_in_run)
	);

	stream_byte_t     pending_bytes[$];
	bmp_pkg::rec_t    expected_records[$];
	logic [7:0]       msg_buf[$];
	logic [7:0]       sect_buf[$];
	logic [7:0]       attr_buf[$];
	logic [7:0]       val_buf[$];
	int               fail_count;
	int               cycles;
	int               send_gap;
	int               stall_gap;
	int               hold_cnt;
	bit               hold_req;
	bit               calm;
	bit               taken;

	// parser state kept by the predictor
	parse_state_t ps;
	logic [15:0] pos, msg_len, sec_left, item_left, wd_total, at_total, a_len, len_limit;
	logic [7:0]  msg_type, a_type, seg_type, entries_left;
	logic [31:0] acc, aggr_asn;
	logic [3:0]  a_flags;
	logic [5:0]  pfx_bits;
	logic        wide, discard;
	bmp_pkg::rec_t run_recs[2];
	int          run_n;
	bit          run_failed;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// queue appends
	task automatic msg_add(input logic [7:0] v);
		msg_buf = {msg_buf, v};
	endtask

	task automatic sect_add(input logic [7:0] v);
		sect_buf = {sect_buf, v};
	endtask

	task automatic attr_add(input logic [7:0] v);
		attr_buf = {attr_buf, v};
	endtask

	task automatic val_add(input logic [7:0] v);
		val_buf = {val_buf, v};
	endtask

	task automatic pend_add(input stream_byte_t v);
		pending_bytes = {pending_bytes, v};
	endtask

	task automatic noise_add(input logic [7:0] v);
		stream_byte_t it;
		it.b = v;
		it.s = 1'b0;
		pend_add(it);
	endtask

	function automatic logic [15:0] sat16(input logic [15:0] v);
		return (v != 16'd0) ? v - 16'd1 : 16'd0;
	endfunction

	task automatic clear_msg();
		pos = '0; msg_len = '0; msg_type = '0; sec_left = '0; item_left = '0;
		wd_total = '0; at_total = '0; acc = '0; aggr_asn = '0; a_flags = '0; a_type = '0;
		a_len = '0; entries_left = '0; wide = 1'b0; seg_type = '0; pfx_bits = '0;
	endtask

	task automatic add_rec(input logic [4:0] k, input logic [31:0] pv, input logic [31:0] sv,
			input logic [5:0] pl, input logic attr, input logic [2:0] err);
		bmp_pkg::rec_t r;
		if (run_n < 2) begin
			r = '0;
			r.kind = k; r.pv = pv; r.sv = sv; r.plen = pl; r.err = err;
			if (attr) begin
				r.flags = a_flags; r.atype = a_type; r.alen = a_len;
			end
			run_recs[run_n] = r;
			run_n++;
		end else begin
			run_recs[1].err = err;
		end
	endtask

	task automatic raise_error(input logic [2:0] code);
		add_rec(bmp_pkg::KIND_ERROR, '0, '0, '0, 1'b0, code);
		run_failed = 1;
	endtask

	task automatic param_end();
		ps = (sec_left != 0) ? PS_PTYPE : PS_SKIP;
	endtask

	task automatic cap_end();
		if (item_left == 0) param_end();
		else ps = PS_CCODE;
	endtask

	task automatic to_attr_len();
		ps = PS_ALEN;
		item_left = 16'd2;
	endtask

	task automatic attr_end();
		ps = (sec_left != 0) ? PS_AFLAGS : PS_NPLEN;
	endtask

	task automatic route_done(input bit nlri);
		add_rec(nlri ? bmp_pkg::KIND_NLRI : bmp_pkg::KIND_WITHDRAWN, acc, '0, pfx_bits,
			1'b0, bmp_pkg::ERR_NONE);
		if (nlri) ps = PS_NPLEN;
		else if (sec_left == 0) to_attr_len();
		else ps = PS_WPLEN;
	endtask

	task automatic route_length(input logic [7:0] b, input bit nlri);
		if (b > 8'd32) begin
			raise_error(bmp_pkg::ERR_PREFIX);
		end else begin
			pfx_bits = b[5:0];
			acc = '0;
			item_left = (16'(b) + 16'd7) >> 3;
			if (item_left == 0) route_done(nlri);
			else ps = nlri ? PS_NPFX : PS_WPFX;
		end
	endtask

	task automatic route_byte(input logic [7:0] b, input bit nlri);
		int k;
		k = ((int'(pfx_bits) + 7) >> 3) - int'(item_left);
		acc = acc | (32'(b) << ((24 - 8 * (k & 3)) & 31));
		item_left = item_left - 16'd1;
		if (item_left == 0) route_done(nlri);
	endtask

	task automatic attr_start();
		add_rec(bmp_pkg::KIND_ATTR_HDR, '0, '0, '0, 1'b1, bmp_pkg::ERR_NONE);
		if (a_type == bmp_pkg::AT_ATOMIC) begin
			if (a_len != 0) raise_error(bmp_pkg::ERR_ATOMIC);
			else begin
				add_rec(bmp_pkg::KIND_ATOMIC, 32'd1, '0, '0, 1'b1, bmp_pkg::ERR_NONE);
				attr_end();
			end
		end else if (a_len == 0) begin
			attr_end();
		end else begin
			item_left = a_len;
			acc = '0;
			ps = PS_AVAL;
		end
	endtask

	// one byte of an attribute value, idx counts from zero
	task automatic attr_value_byte(input int idx, input logic [7:0] b);
		int m;
		if (a_type == bmp_pkg::AT_AS_PATH || a_type == bmp_pkg::AT_AS4_PATH) begin
			if (idx == 0) seg_type = b;
			else if (idx == 1) begin
				entries_left = b;
				wide = (a_type == bmp_pkg::AT_AS4_PATH) || (4 * int'(b) + 2 == int'(a_len));
				acc = '0;
			end else if (entries_left != 0) begin
				acc = {acc[23:0], b};
				m = wide ? 3 : 1;
				if (((idx - 2) & m) == m) begin
					add_rec(a_type == bmp_pkg::AT_AS_PATH ? bmp_pkg::KIND_AS_PATH :
						bmp_pkg::KIND_AS4_PATH, acc, {24'd0, seg_type}, '0, 1'b1,
						bmp_pkg::ERR_NONE);
					acc = '0;
					entries_left = entries_left - 8'd1;
				end
			end
		end else begin
			acc = {acc[23:0], b};
			if (a_type == bmp_pkg::AT_ORIGIN && idx == 0)
				add_rec(bmp_pkg::KIND_ORIGIN, {24'd0, b}, '0, '0, 1'b1, bmp_pkg::ERR_NONE);
			else if (a_type == bmp_pkg::AT_NEXT_HOP && idx == 3)
				add_rec(KIND_NEXT_HOP, acc, '0, '0, 1'b1, bmp_pkg::ERR_NONE);
			else if (a_type == bmp_pkg::AT_MED && idx == 3)
				add_rec(KIND_MED, acc, '0, '0, 1'b1, bmp_pkg::ERR_NONE);
			else if (a_type == bmp_pkg::AT_LOCAL_PREF && idx == 3)
				add_rec(KIND_LOCAL_PREF, acc, '0, '0, 1'b1, bmp_pkg::ERR_NONE);
			else if (a_type == bmp_pkg::AT_AGGR && idx == 1) begin
				aggr_asn = {16'd0, acc[15:0]};
				acc = '0;
			end else if (a_type == bmp_pkg::AT_AGGR && idx == 5)
				add_rec(bmp_pkg::KIND_AGGR, aggr_asn, acc, '0, 1'b1, bmp_pkg::ERR_NONE);
			else if (a_type == bmp_pkg::AT_AGGR4 && idx == 3) begin
				aggr_asn = acc;
				acc = '0;
			end else if (a_type == bmp_pkg::AT_AGGR4 && idx == 7)
				add_rec(bmp_pkg::KIND_AGGR4, aggr_asn, acc, '0, 1'b1, bmp_pkg::ERR_NONE);
		end
	endtask

	task automatic open_fixed(input int off, input logic [7:0] b);
		if (off == 0) begin
			add_rec(bmp_pkg::KIND_VERSION, {24'd0, b}, '0, '0, 1'b0, bmp_pkg::ERR_NONE);
		end else begin
			acc = (off == 1 || off == 3 || off == 5) ? {24'd0, b} : {acc[23:0], b};
			if (off == 2) add_rec(bmp_pkg::KIND_ASN, acc, '0, '0, 1'b0, bmp_pkg::ERR_NONE);
			else if (off == 4)
				add_rec(bmp_pkg::KIND_HOLD, acc, '0, '0, 1'b0, bmp_pkg::ERR_NONE);
			else if (off == 8)
				add_rec(bmp_pkg::KIND_IDENT, acc, '0, '0, 1'b0, bmp_pkg::ERR_NONE);
			else if (off == 9) begin
				sec_left = {8'd0, b};
				ps = (b != 0) ? PS_PTYPE : PS_SKIP;
			end
		end
	endtask

	task automatic parse_one(input logic [7:0] b);
		int idx;
		case (ps)
			PS_HEAD: begin
				if (pos < 16) begin
					if (b != 8'hFF) raise_error(bmp_pkg::ERR_MARKER);
				end else if (pos == 16) msg_len = {b, 8'd0};
				else if (pos == 17) begin
					msg_len[7:0] = b;
					if (msg_len > len_limit) raise_error(bmp_pkg::ERR_TOO_LONG);
				end else begin
					msg_type = b;
					add_rec(bmp_pkg::KIND_HEADER, {24'd0, b}, {16'd0, msg_len}, '0, 1'b0,
						bmp_pkg::ERR_NONE);
					ps = (b == bmp_pkg::MSG_OPEN) ? PS_OPEN :
						(b == bmp_pkg::MSG_UPDATE) ? PS_WLEN : PS_SKIP;
				end
			end
			PS_OPEN: open_fixed(int'(pos) - 19, b);
			PS_PTYPE: begin
				sec_left = sat16(sec_left);
				a_type = b;
				ps = PS_PLEN;
			end
			PS_PLEN: begin
				sec_left = sat16(sec_left);
				item_left = {8'd0, b};
				if (b == 0) param_end();
				else ps = (a_type == bmp_pkg::PARAM_CAP) ? PS_CCODE : PS_PBODY;
			end
			PS_PBODY: begin
				sec_left = sat16(sec_left);
				item_left = sat16(item_left);
				if (item_left == 0) param_end();
			end
			PS_CCODE: begin
				sec_left = sat16(sec_left);
				item_left = sat16(item_left);
				seg_type = b;
				ps = PS_CLEN;
			end
			PS_CLEN: begin
				sec_left = sat16(sec_left);
				item_left = sat16(item_left);
				entries_left = b;
				a_len = {8'd0, b};
				acc = '0;
				if (b == 0) cap_end();
				else ps = PS_CVAL;
			end
			PS_CVAL: begin
				sec_left = sat16(sec_left);
				item_left = sat16(item_left);
				acc = {acc[23:0], b};
				if (seg_type == bmp_pkg::CAP_AS4 && int'(a_len) - int'(entries_left) == 3)
					add_rec(bmp_pkg::KIND_AS4_CAP, acc, '0, '0, 1'b0, bmp_pkg::ERR_NONE);
				entries_left = (entries_left != 0) ? entries_left - 8'd1 : 8'd0;
				if (entries_left == 0) cap_end();
			end
			PS_WLEN: begin
				if (pos == 19) wd_total = {b, 8'd0};
				else begin
					wd_total[7:0] = b;
					sec_left = wd_total;
					if (wd_total != 0) ps = PS_WPLEN;
					else to_attr_len();
				end
			end
			PS_WPLEN: begin
				sec_left = sat16(sec_left);
				route_length(b, 1'b0);
			end
			PS_WPFX: begin
				sec_left = sat16(sec_left);
				route_byte(b, 1'b0);
			end
			PS_ALEN: begin
				if (item_left == 2) begin
					at_total = {b, 8'd0};
					item_left = 16'd1;
				end else begin
					at_total[7:0] = b;
					if (int'(bmp_pkg::UPDATE_FIXED) + int'(wd_total) + int'(at_total) >
							int'(msg_len))
						raise_error(bmp_pkg::ERR_NLRI_NEG);
					else begin
						sec_left = at_total;
						ps = (at_total != 0) ? PS_AFLAGS : PS_NPLEN;
					end
				end
			end
			PS_AFLAGS: begin
				sec_left = sat16(sec_left);
				a_flags = b[7:4];
				ps = PS_ATYPE;
			end
			PS_ATYPE: begin
				sec_left = sat16(sec_left);
				a_type = b;
				item_left = a_flags[0] ? 16'd2 : 16'd1;
				a_len = '0;
				ps = PS_ALENB;
			end
			PS_ALENB: begin
				sec_left = sat16(sec_left);
				a_len = {a_len[7:0], b};
				item_left = sat16(item_left);
				if (item_left == 0) attr_start();
			end
			PS_AVAL: begin
				idx = int'(a_len) - int'(item_left);
				sec_left = sat16(sec_left);
				item_left = sat16(item_left);
				attr_value_byte(idx, b);
				if (item_left == 0) attr_end();
			end
			PS_NPLEN: route_length(b, 1'b1);
			PS_NPFX: route_byte(b, 1'b1);
			default: ;
		endcase
	endtask

	// expected records for one accepted byte
	task automatic predict_records(input logic [7:0] b, input logic start);
		bit ends;
		bmp_pkg::rec_t r;
		run_n = 0;
		run_failed = 0;
		if (start) begin
			clear_msg();
			ps = PS_HEAD;
			discard = 0;
		end
		if (ps != PS_IDLE) begin
			ends = (pos >= 18) && (int'(pos) + 1 >= int'(msg_len));
			parse_one(b);
			if (run_failed) begin
				ps = PS_IDLE;
				discard = 1;
			end else if (ends) ps = PS_IDLE;
			else pos = pos + 16'd1;
			for (int k = 0; k < run_n; k++) begin
				r = run_recs[k];
				r.done = ends;
				r.last = (k == run_n - 1);
				expected_records = {expected_records, r};
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// input acceptance, prediction and output checking
	always @(posedge clk) begin
		bmp_pkg::rec_t e;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[bgp_message_parser_unit] ERROR");
			$finish;
		end
		if (cfg_valid && cfg_ready === 1'b1) len_limit = cfg_data;
		if (in_valid && in_stall === 1'b0) begin
			taken = 1;
			predict_records(message_byte, message_start);
		end
		if (out_valid === 1'b1 && !out_stall) begin
			if (expected_records.size() == 0) begin
				$display("%0t unexpected record kind %0d", $time, record_kind);
				fail_count++;
			end else begin
				e = expected_records.pop_front();
				check_field("record_kind", 32'(e.kind), 32'(record_kind));
				check_field("primary_value", e.pv, primary_value);
				check_field("secondary_value", e.sv, secondary_value);
				check_field("prefix_length", 32'(e.plen), 32'(prefix_length));
				check_field("attr_flags", 32'(e.flags), 32'(attr_flags));
				check_field("attr_type", 32'(e.atype), 32'(attr_type));
				check_field("attr_length", 32'(e.alen), 32'(attr_length));
				check_field("error_code", 32'(e.err), 32'(error_code));
				check_field("message_done", 32'(e.done), 32'(message_done));
				check_field("last_in_run", 32'(e.last), 32'(last_in_run));
			end
		end
	end

	// byte driver with idle bursts
	always @(negedge clk) begin
		stream_byte_t it;
		if (arst_n && (!in_valid || taken)) begin
			taken = 0;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				it = pending_bytes.pop_front();
				in_valid <= 1'b1;
				message_byte <= it.b;
				message_start <= it.s;
				if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// record receiver stall, with one long hold on request
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_stall <= 1'b1;
		end else if (hold_req) begin
			hold_req = 0;
			hold_cnt = LONG_HOLD;
			out_stall <= 1'b1;
		end else if (stall_gap > 0) begin
			stall_gap--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!calm && $urandom_range(0, 7) == 0) stall_gap = $urandom_range(1, 16);
		end
	end

	// message building
	task automatic start_msg(input logic [7:0] mtype);
		msg_buf = {};
		repeat (16) msg_add(8'hFF);
		msg_add(8'd0);
		msg_add(8'd0);
		msg_add(mtype);
	endtask

	task automatic put16(input int v);
		msg_add(v[15:8]);
		msg_add(v[7:0]);
	endtask

	task automatic fill_val(input int n);
		repeat (n) val_add(8'($urandom_range(0, 255)));
	endtask

	// length -1 means the true size
	task automatic send_msg(input int len);
		int n;
		stream_byte_t it;
		n = (len < 0) ? msg_buf.size() : len;
		msg_buf[16] = n[15:8];
		msg_buf[17] = n[7:0];
		foreach (msg_buf[i]) begin
			it.b = msg_buf[i];
			it.s = (i == 0);
			pend_add(it);
		end
	endtask

	task automatic add_attr(input logic [7:0] typ);
		logic [7:0] fl;
		int n;
		n = val_buf.size();
		fl = 8'($urandom_range(0, 255));
		attr_add(fl);
		attr_add(typ);
		if (fl[4]) attr_add(n[15:8]);
		attr_add(n[7:0]);
		attr_buf = {attr_buf, val_buf};
		val_buf = {};
	endtask

	task automatic add_route(input int plen);
		sect_add(plen[7:0]);
		repeat ((plen <= 32) ? (plen + 7) / 8 : 0) sect_add(8'($urandom_range(0, 255)));
	endtask

	task automatic rand_routes(input bit may_break);
		repeat ($urandom_range(0, 3))
			add_route((may_break && $urandom_range(0, 15) == 0) ?
				int'($urandom_range(33, 255)) : int'($urandom_range(0, 32)));
	endtask

	task automatic as_path_val(input bit four);
		int cnt;
		bit w;
		cnt = $urandom_range(0, 4);
		w = four || $urandom_range(0, 1);
		val_add(8'($urandom_range(0, 255)));
		val_add(cnt[7:0]);
		fill_val(cnt * (w ? 4 : 2));
	endtask

	// one attribute of a random kind, sometimes cut short or malformed
	task automatic rand_attr(input bit may_break);
		logic [7:0] t;
		case ($urandom_range(0, 9))
			0: begin t = bmp_pkg::AT_ORIGIN; fill_val(1); end
			1: begin t = bmp_pkg::AT_AS_PATH; as_path_val(0); end
			2: begin t = bmp_pkg::AT_NEXT_HOP; fill_val(4); end
			3: begin t = bmp_pkg::AT_MED; fill_val(4); end
			4: begin t = bmp_pkg::AT_LOCAL_PREF; fill_val(4); end
			5: begin
				t = bmp_pkg::AT_ATOMIC;
				if (may_break && $urandom_range(0, 3) == 0) fill_val(1);
			end
			6: begin t = bmp_pkg::AT_AGGR; fill_val(6); end
			7: begin t = bmp_pkg::AT_AS4_PATH; as_path_val(1); end
			8: begin t = bmp_pkg::AT_AGGR4; fill_val(8); end
			default: begin t = 8'($urandom_range(0, 255)); fill_val($urandom_range(0, 5)); end
		endcase
		if (may_break && val_buf.size() > 0 && $urandom_range(0, 7) == 0)
			void'(val_buf.pop_back());
		if (may_break && $urandom_range(0, 7) == 0) fill_val($urandom_range(1, 3));
		add_attr(t);
	endtask

	task automatic build_update(input bit may_break);
		int alen;
		start_msg(bmp_pkg::MSG_UPDATE);
		sect_buf = {};
		rand_routes(may_break);
		put16(sect_buf.size());
		msg_buf = {msg_buf, sect_buf};
		attr_buf = {};
		repeat ($urandom_range(0, 5)) rand_attr(may_break);
		alen = attr_buf.size();
		if (may_break && $urandom_range(0, 9) == 0) alen = alen + $urandom_range(1, 300);
		put16(alen);
		msg_buf = {msg_buf, attr_buf};
		sect_buf = {};
		rand_routes(may_break);
		msg_buf = {msg_buf, sect_buf};
	endtask

	task automatic build_open(input bit may_break);
		int n, c;
		start_msg(bmp_pkg::MSG_OPEN);
		repeat (9) msg_add(8'($urandom_range(0, 255)));
		sect_buf = {};
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 3) != 0) begin
				val_buf = {};
				repeat ($urandom_range(1, 2)) begin
					if ($urandom_range(0, 1)) begin
						val_add(bmp_pkg::CAP_AS4);
						val_add(8'd4);
						fill_val(4);
					end else begin
						c = $urandom_range(0, 3);
						val_add(8'($urandom_range(0, 255)));
						val_add(c[7:0]);
						fill_val(c);
					end
				end
				sect_add(bmp_pkg::PARAM_CAP);
				sect_add(8'(val_buf.size()));
				sect_buf = {sect_buf, val_buf};
				val_buf = {};
			end else begin
				n = $urandom_range(0, 3);
				sect_add(8'($urandom_range(3, 255)));
				sect_add(n[7:0]);
				repeat (n) sect_add(8'($urandom_range(0, 255)));
			end
		end
		n = sect_buf.size();
		if (may_break && $urandom_range(0, 7) == 0) n = $urandom_range(0, 255);
		msg_add(n[7:0]);
		msg_buf = {msg_buf, sect_buf};
	endtask

	task automatic rand_message();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 11) begin
			build_update(1);
			send_msg(($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 80)) : -1);
		end else if (sel < 15) begin
			build_open(1);
			send_msg(($urandom_range(0, 15) == 0) ? int'($urandom_range(0, 60)) : -1);
		end else if (sel < 17) begin
			start_msg(8'($urandom_range(3, 255)));
			repeat ($urandom_range(0, 6)) msg_add(8'($urandom_range(0, 255)));
			send_msg(-1);
		end else if (sel == 17) begin
			build_update(0);
			msg_buf[$urandom_range(0, 15)] = 8'($urandom_range(0, 254));
			send_msg(-1);
		end else begin
			// noise outside any message
			msg_buf = {};
			repeat ($urandom_range(1, 6)) msg_add(8'($urandom_range(0, 255)));
			foreach (msg_buf[i]) noise_add(msg_buf[i]);
		end
	endtask

	task automatic drain();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_records.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk);
		while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic rand_phase(input int n_items);
		int start_sz;
		start_sz = pending_bytes.size();
		while (pending_bytes.size() - start_sz < n_items) rand_message();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		message_byte = 8'd0;
		message_start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		out_stall = 1'b0;
		fail_count = 0;
		cycles = 0;
		send_gap = 0;
		stall_gap = 0;
		hold_cnt = 0;
		hold_req = 0;
		calm = 0;
		taken = 0;
		clear_msg();
		ps = PS_IDLE;
		discard = 0;
		len_limit = bmp_pkg::RESET_MAX_LEN;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: keepalive, noise, full update, open with as4 cap, bad marker, too long
		start_msg(8'd4);
		send_msg(-1);
		noise_add(8'h00);
		noise_add(8'hFF);
		start_msg(bmp_pkg::MSG_UPDATE);
		put16(6);
		msg_buf = {msg_buf, 8'd32, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'd0};
		attr_buf = {};
		val_buf = {8'd0};
		add_attr(bmp_pkg::AT_ORIGIN);
		val_buf = {8'd2, 8'd2, 8'h00, 8'h01, 8'hFF, 8'hFF};
		add_attr(bmp_pkg::AT_AS_PATH);
		fill_val(4);
		add_attr(bmp_pkg::AT_NEXT_HOP);
		fill_val(4);
		add_attr(bmp_pkg::AT_MED);
		fill_val(4);
		add_attr(bmp_pkg::AT_LOCAL_PREF);
		add_attr(bmp_pkg::AT_ATOMIC);
		fill_val(6);
		add_attr(bmp_pkg::AT_AGGR);
		val_buf = {8'd2, 8'd1};
		fill_val(4);
		add_attr(bmp_pkg::AT_AS4_PATH);
		fill_val(8);
		add_attr(bmp_pkg::AT_AGGR4);
		put16(attr_buf.size());
		msg_buf = {msg_buf, attr_buf, 8'd24, 8'd10, 8'd1, 8'd2, 8'd33};
		send_msg(-1);
		start_msg(bmp_pkg::MSG_OPEN);
		msg_buf = {msg_buf, 8'd4, 8'hFD, 8'hE8, 8'd0, 8'd90, 8'd10, 8'd0, 8'd0, 8'd1, 8'd8,
			bmp_pkg::PARAM_CAP, 8'd6, bmp_pkg::CAP_AS4, 8'd4, 8'h00, 8'h01, 8'h00, 8'h00};
		send_msg(-1);
		build_update(0);
		msg_buf[3] = 8'h7F;
		send_msg(-1);
		start_msg(8'd3);
		send_msg(5000);
		drain();

		// smallest limit: only bare headers get through
		write_limit(16'd19);
		repeat (4) begin
			start_msg(8'd4);
			send_msg(-1);
			rand_message();
		end
		drain();

		// largest limit, with one long receiver hold while bytes keep coming
		write_limit(16'd65535);
		hold_req = 1;
		rand_phase(350);
		drain();

		write_limit(16'($urandom_range(40, 120)));
		rand_phase(300);
		drain();

		// back to the reset limit, no idling at the end
		write_limit(bmp_pkg::RESET_MAX_LEN);
		calm = 1;
		rand_phase(300);
		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0 && expected_records.size() == 0) begin
			$display("[bgp_message_parser_unit] OK");
		end else begin
			$display("[bgp_message_parser_unit] ERROR");
		end
		$finish;
	end

endmodule
